// ===== hdl/psp_pkg.sv =====
`timescale 1ns / 1ps
// psp_pkg: shared types and constants for the particle slot pool.
// No dependencies; imported by particle_slot_pool_core and its bench.
package psp_pkg;

  localparam int NUM_SLOTS_DEF  = 128;
  localparam int COORD_BITS_DEF = 32;

  // fixed widths of the item fields
  localparam int FIELD_W = 32;
  localparam int SEL_W   = 7;
  localparam int CNT_O_W = 8;

  typedef enum logic [1:0] {
    OP_SPAWN  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DEACT  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPAWN,
    ST_UPD,
    ST_UPD_TAIL,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/particle_slot_pool_core.sv =====
`timescale 1ns / 1ps
// particle_slot_pool_core: slot table of particles with spawn, update-all,
// deactivate and read. Uses psp_pkg.

// One item is handled at a time; in_ready is high only while the sequencer
// is idle. Spawn walks the active bits from slot 0 to the lowest free slot
// (or finishes at once when the pool is full); update-all walks the slot
// memory one slot per cycle through a single read port and one shared pair
// of adders; deactivate needs no memory access and read makes one memory
// read. A finished result waits in the output register until taken, and
// the next item may be accepted meanwhile. Active bits are flip-flops
// cleared at reset, so no clearing pass is needed; position and velocity
// sit in an uninitialised memory.
module particle_slot_pool_core
  import psp_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic signed [FIELD_W-1:0]  in_pos_x,
  input  logic signed [FIELD_W-1:0]  in_pos_y,
  input  logic signed [FIELD_W-1:0]  in_vel_x,
  input  logic signed [FIELD_W-1:0]  in_vel_y,
  input  logic [SEL_W-1:0]           in_slot_sel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ok,
  output logic [SEL_W-1:0]           out_slot_out,
  output logic signed [FIELD_W-1:0]  out_x,
  output logic signed [FIELD_W-1:0]  out_y,
  output logic                       out_active,
  output logic [CNT_O_W-1:0]         out_active_count
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int C     = COORD_BITS;
  localparam int MEM_W = 4 * C;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // word layout: {pos_x, pos_y, vel_x, vel_y}
  logic [MEM_W-1:0] slot_mem [NUM_SLOTS];
  logic [MEM_W-1:0] mem_q_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             p1_r, p1_nxt;
  logic [IDX_W-1:0] p_idx_r, p_idx_nxt;
  logic             p_act_r, p_act_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;

  op_t              op_r;
  logic [SEL_W-1:0] sel_r;
  logic [MEM_W-1:0] spawn_data_r;

  logic               res_ok_r, res_ok_nxt;
  logic [SEL_W-1:0]   res_slot_r, res_slot_nxt;
  logic [FIELD_W-1:0] res_x_r, res_x_nxt;
  logic [FIELD_W-1:0] res_y_r, res_y_nxt;
  logic               res_act_r, res_act_nxt;

  logic               out_ok_r;
  logic [SEL_W-1:0]   out_slot_r;
  logic [FIELD_W-1:0] out_x_r;
  logic [FIELD_W-1:0] out_y_r;
  logic               out_act_r;
  logic [CNT_O_W-1:0] out_cnt_r;

  logic             sp_wr;
  logic             out_load;
  logic             sel_bad;
  logic [IDX_W-1:0] sel_idx;
  logic [C-1:0]     sum_x;
  logic [C-1:0]     sum_y;

  assign sel_bad = (32'(sel_r) >= 32'(NUM_SLOTS));
  assign sel_idx = IDX_W'(sel_r);

  // shared adder pair for the update walk, wraps modulo 2^C
  assign sum_x = mem_q_r[4*C-1 -: C] + mem_q_r[2*C-1 -: C];
  assign sum_y = mem_q_r[3*C-1 -: C] + mem_q_r[C-1 -: C];

  assign wr_en   = sp_wr || (p1_r && p_act_r);
  assign wr_addr = sp_wr ? idx_r : p_idx_r;
  assign wr_data = sp_wr ? spawn_data_r : {sum_x, sum_y, mem_q_r[2*C-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= slot_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    p1_nxt       = 1'b0;
    p_idx_nxt    = p_idx_r;
    p_act_nxt    = p_act_r;
    active_nxt   = active_r;
    count_nxt    = count_r;
    res_ok_nxt   = res_ok_r;
    res_slot_nxt = res_slot_r;
    res_x_nxt    = res_x_r;
    res_y_nxt    = res_y_r;
    res_act_nxt  = res_act_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    sp_wr        = 1'b0;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_ok_nxt   = 1'b1;
        res_slot_nxt = '0;
        res_x_nxt    = '0;
        res_y_nxt    = '0;
        res_act_nxt  = 1'b0;
        idx_nxt      = '0;
        unique case (op_r)
          OP_SPAWN: begin
            if (count_r == CNT_W'(NUM_SLOTS)) begin
              res_ok_nxt = 1'b0;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_SPAWN;
            end
          end
          OP_UPDATE: begin
            state_nxt = ST_UPD;
          end
          OP_DEACT: begin
            state_nxt = ST_DONE;
            if (sel_bad) begin
              res_ok_nxt = 1'b0;
            end else if (active_r[sel_idx]) begin
              active_nxt[sel_idx] = 1'b0;
              count_nxt           = count_r - CNT_W'(1);
            end
          end
          OP_READ: begin
            if (sel_bad) begin
              res_ok_nxt = 1'b0;
              state_nxt  = ST_DONE;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = sel_idx;
              res_slot_nxt = sel_r;
              res_act_nxt  = active_r[sel_idx];
              state_nxt    = ST_RDWAIT;
            end
          end
        endcase
      end
      ST_SPAWN: begin
        // a free slot exists, so the walk stops before running off the end
        if (!active_r[idx_r]) begin
          sp_wr             = 1'b1;
          active_nxt[idx_r] = 1'b1;
          count_nxt         = count_r + CNT_W'(1);
          res_slot_nxt      = SEL_W'(idx_r);
          state_nxt         = ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_UPD: begin
        // read slot idx now, write it back next cycle
        rd_en     = 1'b1;
        p1_nxt    = 1'b1;
        p_idx_nxt = idx_r;
        p_act_nxt = active_r[idx_r];
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_UPD_TAIL;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_UPD_TAIL: begin
        state_nxt = ST_DONE;
      end
      ST_RDWAIT: begin
        res_x_nxt = FIELD_W'(mem_q_r[4*C-1 -: C]);
        res_y_nxt = FIELD_W'(mem_q_r[3*C-1 -: C]);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      p1_r        <= 1'b0;
      active_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      p1_r     <= p1_nxt;
      active_r <= active_nxt;
      count_r  <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r         <= op_t'(in_opcode);
      sel_r        <= in_slot_sel;
      spawn_data_r <= {C'(in_pos_x), C'(in_pos_y), C'(in_vel_x), C'(in_vel_y)};
    end
    p_idx_r    <= p_idx_nxt;
    p_act_r    <= p_act_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_act_r  <= res_act_nxt;
    if (out_load) begin
      out_ok_r   <= res_ok_r;
      out_slot_r <= res_slot_r;
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_act_r  <= res_act_r;
      out_cnt_r  <= CNT_O_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_slot_out     = out_slot_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_active       = out_act_r;
  assign out_active_count = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_SLOTS))
    else $error("active count above pool size");

  a_count_popcount: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(active_r)))
    else $error("active count out of step with active bits");

  a_upd_active_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |=> $stable(active_r))
    else $error("active bits changed during update walk");

  a_spawn_free: assert property (@(posedge clk) disable iff (!rst_n)
    sp_wr |-> !active_r[idx_r])
    else $error("spawn into an active slot");

endmodule

// ===== tb/particle_slot_pool_core_tb.sv =====
`timescale 1ns / 1ps
// particle_slot_pool_core_tb: self-checking bench for the particle slot pool.
// Queue-fed driver, clocked monitor and a slot-table predictor; uses psp_pkg
// and particle_slot_pool_core.
module particle_slot_pool_core_tb
  import psp_pkg::*;
();

  localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_ITEMS  = 1600;

  typedef struct packed {
    op_t                      op;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic [SEL_W-1:0]          sel;
  } pool_op_t;

  typedef struct packed {
    logic                      ok;
    logic [SEL_W-1:0]          slot;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic                      act;
    logic [CNT_O_W-1:0]        cnt;
  } pool_reply_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_opcode = '0;
  logic signed [FIELD_W-1:0] in_pos_x = '0;
  logic signed [FIELD_W-1:0] in_pos_y = '0;
  logic signed [FIELD_W-1:0] in_vel_x = '0;
  logic signed [FIELD_W-1:0] in_vel_y = '0;
  logic [SEL_W-1:0]          in_slot_sel = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_ok;
  logic [SEL_W-1:0]          out_slot_out;
  logic signed [FIELD_W-1:0] out_x;
  logic signed [FIELD_W-1:0] out_y;
  logic                      out_active;
  logic [CNT_O_W-1:0]        out_active_count;

  particle_slot_pool_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_slot_sel      (in_slot_sel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_slot_out     (out_slot_out),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_active       (out_active),
    .out_active_count (out_active_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // slot table as the block should hold it
  bit                        pool_live    [NUM_SLOTS];
  bit                        pool_written [NUM_SLOTS];
  logic signed [FIELD_W-1:0] pool_pos_x   [NUM_SLOTS];
  logic signed [FIELD_W-1:0] pool_pos_y   [NUM_SLOTS];
  logic signed [FIELD_W-1:0] pool_vel_x   [NUM_SLOTS];
  logic signed [FIELD_W-1:0] pool_vel_y   [NUM_SLOTS];
  logic [CNT_O_W-1:0]        live_total = '0;

  pool_op_t    op_queue[$];
  pool_reply_t reply_queue[$];
  pool_op_t    held_op;
  bit          op_held = 1'b0;
  bit          steady = 1'b0;
  int          mismatch_count = 0;
  int          reply_index = 0;
  int          cycle_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH reply %0d %s: got %h want %h", reply_index, what, got, want);
    mismatch_count++;
  endtask

  // applies one accepted item to the slot table and queues its reply
  task automatic apply_pool_op(input pool_op_t it);
    pool_reply_t r;
    r = '0;
    r.ok = 1'b1;
    case (it.op)
      OP_SPAWN: begin
        r.ok = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!pool_live[k]) begin
            pool_pos_x[k]   = it.pos_x;
            pool_pos_y[k]   = it.pos_y;
            pool_vel_x[k]   = it.vel_x;
            pool_vel_y[k]   = it.vel_y;
            pool_live[k]    = 1'b1;
            pool_written[k] = 1'b1;
            live_total++;
            r.ok   = 1'b1;
            r.slot = k[SEL_W-1:0];
            break;
          end
        end
      end
      OP_UPDATE: begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (pool_live[k]) begin
            pool_pos_x[k] = pool_pos_x[k] + pool_vel_x[k];
            pool_pos_y[k] = pool_pos_y[k] + pool_vel_y[k];
          end
        end
      end
      default: begin
        if (it.sel >= NUM_SLOTS) begin
          r.ok = 1'b0;
        end else if (it.op == OP_DEACT) begin
          if (pool_live[it.sel]) begin
            pool_live[it.sel] = 1'b0;
            live_total--;
          end
        end else begin
          r.slot = it.sel;
          r.x    = pool_pos_x[it.sel];
          r.y    = pool_pos_y[it.sel];
          r.act  = pool_live[it.sel];
        end
      end
    endcase
    r.cnt = live_total;
    reply_queue.insert(reply_queue.size(), r);
  endtask

  // driver: one item held on the port until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_pool_op(held_op);
        op_held = 1'b0;
      end
      if (!op_held) begin
        if (op_queue.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
          held_op = op_queue.pop_front();
          op_held = 1'b1;
          in_opcode   <= held_op.op;
          in_pos_x    <= held_op.pos_x;
          in_pos_y    <= held_op.pos_y;
          in_vel_x    <= held_op.vel_x;
          in_vel_y    <= held_op.vel_y;
          in_slot_sel <= held_op.sel;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pool_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("unexpected item", '0, '0);
        end else begin
          want = reply_queue.pop_front();
          if (out_ok !== want.ok)
            report_mismatch("ok", 32'(out_ok), 32'(want.ok));
          if (out_slot_out !== want.slot)
            report_mismatch("slot_out", 32'(out_slot_out), 32'(want.slot));
          if (out_x !== want.x)
            report_mismatch("out_x", out_x, want.x);
          if (out_y !== want.y)
            report_mismatch("out_y", out_y, want.y);
          if (out_active !== want.act)
            report_mismatch("out_active", 32'(out_active), 32'(want.act));
          if (out_active_count !== want.cnt)
            report_mismatch("active_count", 32'(out_active_count), 32'(want.cnt));
        end
        reply_index++;
      end
      out_ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return $urandom_range(32'h3_ffff) - 32'h2_0000;  // within +-2.0
      default: return $urandom;
    endcase
  endfunction

  // random slot that is live (or merely written), from a random start; -1 if none
  function automatic int pick_slot(input bit want_live);
    int start;
    int k;
    start = $urandom_range(NUM_SLOTS - 1);
    for (int n = 0; n < NUM_SLOTS; n++) begin
      k = (start + n) % NUM_SLOTS;
      if (want_live ? pool_live[k] : pool_written[k])
        return k;
    end
    return -1;
  endfunction

  // queue kept short so that reads can rely on the written bits seen so far
  task automatic queue_op(input op_t op, input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] vx, input logic [31:0] vy,
                          input logic [SEL_W-1:0] sel);
    pool_op_t it;
    while (op_queue.size() > 1) @(posedge clk);
    it.op    = op;
    it.pos_x = px;
    it.pos_y = py;
    it.vel_x = vx;
    it.vel_y = vy;
    it.sel   = sel;
    op_queue.insert(op_queue.size(), it);
  endtask

  // mode 0 fills the pool past exhaustion, 1 is mixed, 2 drains it
  task automatic queue_random(input int mode);
    int   roll;
    int   s;
    op_t  op;
    logic [SEL_W-1:0] sel;
    roll = $urandom_range(99);
    sel  = SEL_W'($urandom_range(NUM_SLOTS - 1));
    case (mode)
      0: begin
        if (roll < 85)      op = OP_SPAWN;
        else if (roll < 90) op = OP_UPDATE;
        else if (roll < 96) op = OP_READ;
        else                op = OP_DEACT;
      end
      1: begin
        if (roll < 40)      op = OP_SPAWN;
        else if (roll < 55) op = OP_UPDATE;
        else if (roll < 80) op = OP_READ;
        else                op = OP_DEACT;
      end
      default: begin
        if (roll < 10)      op = OP_SPAWN;
        else if (roll < 20) op = OP_UPDATE;
        else if (roll < 45) op = OP_READ;
        else                op = OP_DEACT;
      end
    endcase
    if (op == OP_READ) begin
      s = pick_slot(1'b0);
      if (s < 0) op = OP_SPAWN;
      else sel = s[SEL_W-1:0];
    end else if (op == OP_DEACT && $urandom_range(3) != 0) begin
      s = pick_slot(1'b1);
      if (s >= 0) sel = s[SEL_W-1:0];
    end
    queue_op(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(), sel);
  endtask

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    queue_op(OP_DEACT, '0, '0, '0, '0, 7'd0);     // free slot, nothing to do
    queue_op(OP_SPAWN, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 7'h7f);
    queue_op(OP_SPAWN, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001, 7'h00);
    queue_op(OP_SPAWN, 32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 7'h55);
    queue_op(OP_UPDATE, '1, '1, '1, '1, 7'h7f);   // wraps both edges
    queue_op(OP_READ, '0, '0, '0, '0, 7'd0);
    queue_op(OP_READ, '0, '0, '0, '0, 7'd1);
    queue_op(OP_READ, '0, '0, '0, '0, 7'd2);
    queue_op(OP_DEACT, '0, '0, '0, '0, 7'd1);
    queue_op(OP_READ, '0, '0, '0, '0, 7'd1);      // inactive slot keeps its position
    queue_op(OP_UPDATE, '0, '0, '0, '0, 7'd0);
    queue_op(OP_READ, '0, '0, '0, '0, 7'd1);
    queue_op(OP_READ, '0, '0, '0, '0, 7'd0);
    queue_op(OP_SPAWN, 32'h0001_8000, 32'hfffe_8000, 32'h0000_4000, 32'hffff_c000, 7'h2a);
    queue_op(OP_READ, '0, '0, '0, '0, 7'd1);
    queue_op(OP_DEACT, '0, '0, '0, '0, 7'd0);
    queue_op(OP_DEACT, '0, '0, '0, '0, 7'd0);     // second time is a no-op
    queue_op(OP_DEACT, '0, '0, '0, '0, 7'h7f);    // top index, never spawned
    queue_op(OP_UPDATE, '0, '0, '0, '0, 7'd0);
    queue_op(OP_READ, '0, '0, '0, '0, 7'd2);
    queue_op(OP_SPAWN, '1, '0, '1, '0, 7'd0);     // reuses slot 0
    queue_op(OP_READ, '0, '0, '0, '0, 7'd0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      steady = (i >= 1000 && i < 1200);
      phase  = (i / 200) % 4;
      queue_random(phase == 3 ? 1 : phase);
    end
    steady = 1'b0;

    while (op_queue.size() != 0 || op_held || reply_queue.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 16) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
